/* hdl/bxn_pkg.sv */
`default_nettype none

package bxn_pkg;

  // field widths of the stream items
  localparam int ACT_W    = 32;
  localparam int WGT_W    = 32;
  localparam int THR_W    = 16;
  localparam int PACK_W   = 32;
  localparam int WIDX_W   = 5;
  localparam int SCORE_W  = 12;
  localparam int NIDX_W   = 10;

  // bus widths, padded to whole bytes
  localparam int IN_TDATA_W  = 88;
  localparam int OUT_TDATA_W = 72;

  // configuration port
  localparam int CFG_W     = 11;
  localparam int CFG_IDX_W = 2;

  localparam logic [CFG_IDX_W-1:0] CFG_INPUT_BITS   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_NEURON_COUNT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_LAYER_MODE   = 2'd2;

  localparam logic [CFG_W-1:0] RST_INPUT_BITS   = 11'd1024;
  localparam logic [CFG_W-1:0] RST_NEURON_COUNT = 11'd1024;

  // layer modes
  localparam logic MODE_THRESHOLD = 1'b0;
  localparam logic MODE_SCORE     = 1'b1;

  // input item, activation word in the lowest bits
  typedef struct packed {
    logic              polarity;
    logic [THR_W-1:0]  threshold;
    logic [WGT_W-1:0]  weight_word;
    logic [ACT_W-1:0]  activation_word;
  } item_t;

  // result item, packed word in the lowest bits
  typedef struct packed {
    logic [NIDX_W-1:0]  prediction;
    logic [NIDX_W-1:0]  neuron_index;
    logic [SCORE_W-1:0] score;
    logic [WIDX_W-1:0]  word_index;
    logic [PACK_W-1:0]  packed_word;
  } result_t;

  // layer configuration registers
  typedef struct packed {
    logic             layer_mode;
    logic [CFG_W-1:0] neuron_count;
    logic [CFG_W-1:0] act_len;
  } cfg_t;

endpackage

`default_nettype wire

/* hdl/bnn_xnor_popcount_neuron_engine_core.sv */
`default_nettype none

// Binarized layer engine: each transfer brings one 32-bit activation word and the
// matching weight word of the current neuron; matches (xnor) are counted and summed
// over the neuron's words. Mode 0 packs one thresholded bit per neuron and sends a
// word every 32 neurons or at the end of the layer; mode 1 sends the score
// 2*matches minus the input length for every neuron and the first argmax with the
// last one. One item is taken every cycle while the input side is not stalled; a
// result is presented once the item that completes it has passed the input
// register and then one pass of xnor, popcount, accumulate and compare into the
// result register. The input side stalls only while the result register holds a
// result that is not taken; out_tready reaches in_tready through logic.
// Configuration is to be written only while idle; the block does not enforce this.
// A length shortened mid-layer ends the current neuron or layer at once.
module bnn_xnor_popcount_neuron_engine_core #(
  parameter int MAX_INPUT_BITS = 1024,
  parameter int MAX_NEURONS    = 1024
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  // activation_word, weight_word, threshold, polarity
  input  wire logic [bxn_pkg::IN_TDATA_W-1:0]    in_tdata,
  input  wire logic                              in_tvalid,
  output logic                                   in_tready,
  // packed_word, word_index, score, neuron_index, prediction
  output logic [bxn_pkg::OUT_TDATA_W-1:0]        out_tdata,
  output logic                                   out_tlast,
  output logic                                   out_tvalid,
  input  wire logic                              out_tready,
  input  wire logic                              cfg_we,
  input  wire logic [bxn_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  wire logic [bxn_pkg::CFG_W-1:0]         cfg_wdata
);

  bxn_pkg::cfg_t    cfg_r;
  bxn_pkg::item_t   s1_item_r;
  logic             s1_valid_r;
  logic             stall;
  logic             proceed;
  bxn_pkg::result_t out_result;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.act_len      <= bxn_pkg::RST_INPUT_BITS;
      cfg_r.neuron_count <= bxn_pkg::RST_NEURON_COUNT;
      cfg_r.layer_mode   <= bxn_pkg::MODE_THRESHOLD;
    end else if (cfg_we) begin
      case (cfg_index)
        bxn_pkg::CFG_INPUT_BITS:   cfg_r.act_len      <= cfg_wdata;
        bxn_pkg::CFG_NEURON_COUNT: cfg_r.neuron_count <= cfg_wdata;
        bxn_pkg::CFG_LAYER_MODE:   cfg_r.layer_mode   <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  // input register
  assign proceed   = s1_valid_r && !stall;
  assign in_tready = !s1_valid_r || proceed;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_tvalid && in_tready) begin
      s1_valid_r <= 1'b1;
    end else if (proceed) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      s1_item_r <= bxn_pkg::item_t'(in_tdata[$bits(bxn_pkg::item_t)-1:0]);
    end
  end

  bxn_layer #(
    .MAX_INPUT_BITS (MAX_INPUT_BITS),
    .MAX_NEURONS    (MAX_NEURONS)
  ) u_layer (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg_r),
    .step_en    (proceed),
    .item       (s1_item_r),
    .stall      (stall),
    .out_valid  (out_tvalid),
    .out_ready  (out_tready),
    .out_result (out_result),
    .out_last   (out_tlast)
  );

  assign out_tdata = bxn_pkg::OUT_TDATA_W'(out_result);

  // a result never carries fields of both modes
  a_mode_fields : assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_result.packed_word != '0 || out_result.word_index != '0)
    |-> out_result.score == '0 && out_result.neuron_index == '0
        && out_result.prediction == '0)
    else $error("result mixes threshold and score fields");

  // a new result only follows an item held in the input register
  a_result_source : assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_tvalid) |-> $past(s1_valid_r))
    else $error("result without a pending item");

  // the input side stalls only behind a result that is not taken
  a_stall_cause : assert property (@(posedge clk) disable iff (!rst_n)
    s1_valid_r && !in_tready |-> out_tvalid && !out_tready)
    else $error("input stalled without output backpressure");

endmodule

`default_nettype wire

/* hdl/bxn_popcount.sv */
`default_nettype none

module bxn_popcount (
  input  wire logic [bxn_pkg::ACT_W-1:0] act_word,
  input  wire logic [bxn_pkg::WGT_W-1:0] wgt_word,
  input  wire logic                      last_word,
  input  wire logic [4:0]                tail,
  output logic [5:0]                     ones
);

  logic [31:0] equal;
  logic [31:0] keep_mask;
  logic [31:0] masked;
  logic [31:0] v1;
  logic [31:0] v2;
  logic [31:0] v3;
  logic [31:0] v4;
  logic [31:0] v5;

  // matching bits, tail of the last word cut off
  always_comb begin
    equal     = ~(act_word ^ wgt_word);
    keep_mask = (tail == 5'd0) ? 32'hffff_ffff : ((32'd1 << tail) - 32'd1);
    masked    = last_word ? (equal & keep_mask) : equal;
  end

  // swar bit count
  always_comb begin
    v1   = masked - ((masked >> 1) & 32'h5555_5555);
    v2   = (v1 & 32'h3333_3333) + ((v1 >> 2) & 32'h3333_3333);
    v3   = (v2 + (v2 >> 4)) & 32'h0f0f_0f0f;
    v4   = v3 + (v3 >> 8);
    v5   = v4 + (v4 >> 16);
    ones = v5[5:0];
  end

endmodule

`default_nettype wire

/* hdl/bxn_layer.sv */
`default_nettype none

module bxn_layer #(
  parameter int MAX_INPUT_BITS = 1024,
  parameter int MAX_NEURONS    = 1024
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire bxn_pkg::cfg_t     cfg,
  input  wire logic              step_en,
  input  wire bxn_pkg::item_t    item,
  output logic                   stall,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output bxn_pkg::result_t       out_result,
  output logic                   out_last
);

  localparam int MAX_WORDS = (MAX_INPUT_BITS + 31) / 32;
  localparam int BW   = $clog2(MAX_INPUT_BITS + 1);
  localparam int EW   = (BW > bxn_pkg::CFG_W) ? BW : bxn_pkg::CFG_W;
  localparam int CMPW = BW + 1;
  localparam int WW   = (MAX_WORDS > 1) ? $clog2(MAX_WORDS) : 1;
  localparam int MCW  = $clog2(32 * MAX_WORDS + 1);
  localparam int TCW  = (MCW > bxn_pkg::THR_W) ? MCW : bxn_pkg::THR_W;
  localparam int SXW  = (MCW + 2 > bxn_pkg::SCORE_W) ? MCW + 2 : bxn_pkg::SCORE_W;
  localparam int NW   = $clog2(MAX_NEURONS);
  localparam int CNW  = $clog2(MAX_NEURONS + 1);
  localparam int CEW  = (CNW > bxn_pkg::CFG_W) ? CNW : bxn_pkg::CFG_W;
  localparam int NCW  = CNW + 1;
  localparam int NXW  = (NW > bxn_pkg::NIDX_W) ? NW : bxn_pkg::NIDX_W;

  localparam logic [SXW-1:0] BEST_RST = {1'b1, {(SXW - 1){1'b0}}};

  // layer state
  logic [WW-1:0]     wp_r,      wp_nxt;
  logic [MCW-1:0]    match_r,   match_nxt;
  logic [NW-1:0]     np_r,      np_nxt;
  logic [31:0]       packed_r,  packed_nxt;
  logic [SXW-1:0]    best_s_r,  best_s_nxt;
  logic [NW-1:0]     best_n_r,  best_n_nxt;
  logic              out_valid_r;
  bxn_pkg::result_t  result_r;
  logic              last_r;

  logic [EW-1:0]     ib_ext;
  logic [BW-1:0]     bits;
  logic [CMPW-1:0]   words;
  logic              last_word;
  logic [5:0]        ones;
  logic [MCW-1:0]    match_sum;
  logic [CEW-1:0]    nc_ext;
  logic [CNW-1:0]    count;
  logic              last_neuron;
  logic [NXW-1:0]    n_w;
  logic [4:0]        n5;
  logic              ge;
  logic              hit;
  logic [31:0]       packed_upd;
  logic              emit;
  logic [SXW-1:0]    score_v;
  logic              better;
  logic [NW-1:0]     best_upd;
  logic [NXW-1:0]    best_w;
  logic              has_res;
  logic              res_last;
  bxn_pkg::result_t  res;

  // effective lengths, saturated to the supported range
  always_comb begin
    ib_ext = EW'(cfg.act_len);
    if (ib_ext == '0) begin
      bits = BW'(1);
    end else if (ib_ext > EW'(MAX_INPUT_BITS)) begin
      bits = BW'(MAX_INPUT_BITS);
    end else begin
      bits = BW'(ib_ext);
    end
    nc_ext = CEW'(cfg.neuron_count);
    if (nc_ext == '0) begin
      count = CNW'(1);
    end else if (nc_ext > CEW'(MAX_NEURONS)) begin
      count = CNW'(MAX_NEURONS);
    end else begin
      count = CNW'(nc_ext);
    end
  end

  assign words       = (CMPW'(bits) + CMPW'(31)) >> 5;
  assign last_word   = (CMPW'(wp_r) + CMPW'(1)) >= words;
  assign last_neuron = (NCW'(np_r) + NCW'(1)) >= NCW'(count);

  bxn_popcount u_popcount (
    .act_word  (item.activation_word),
    .wgt_word  (item.weight_word),
    .last_word (last_word),
    .tail      (bits[4:0]),
    .ones      (ones)
  );

  // accumulate, threshold and score
  always_comb begin
    match_sum  = match_r + MCW'(ones);
    n_w        = NXW'(np_r);
    n5         = n_w[4:0];
    ge         = TCW'(match_sum) >= TCW'(item.threshold);
    hit        = (ge == item.polarity);
    packed_upd = packed_r | (hit ? (32'd1 << n5) : 32'd0);
    emit       = (n5 == 5'd31) || last_neuron;
    score_v    = (SXW'(match_sum) << 1) - SXW'(bits);
    better     = $signed(score_v) > $signed(best_s_r);
    best_upd   = better ? np_r : best_n_r;
    best_w     = NXW'(best_upd);
  end

  // next state and result of one word
  always_comb begin
    wp_nxt     = wp_r;
    match_nxt  = match_r;
    np_nxt     = np_r;
    packed_nxt = packed_r;
    best_s_nxt = best_s_r;
    best_n_nxt = best_n_r;
    has_res    = 1'b0;
    res_last   = 1'b0;
    res        = '0;
    if (step_en) begin
      if (!last_word) begin
        wp_nxt    = wp_r + WW'(1);
        match_nxt = match_sum;
      end else begin
        wp_nxt    = '0;
        match_nxt = '0;
        if (cfg.layer_mode == bxn_pkg::MODE_THRESHOLD) begin
          if (emit) begin
            has_res         = 1'b1;
            res.packed_word = packed_upd;
            res.word_index  = n_w[9:5];
            packed_nxt      = '0;
          end else begin
            packed_nxt = packed_upd;
          end
        end else begin
          has_res          = 1'b1;
          res.score        = score_v[bxn_pkg::SCORE_W-1:0];
          res.neuron_index = n_w[bxn_pkg::NIDX_W-1:0];
          if (better) begin
            best_s_nxt = score_v;
            best_n_nxt = np_r;
          end
          if (last_neuron) begin
            res.prediction = best_w[bxn_pkg::NIDX_W-1:0];
          end
        end
        // end of layer returns everything to its reset value
        if (last_neuron) begin
          res_last   = 1'b1;
          np_nxt     = '0;
          packed_nxt = '0;
          best_s_nxt = BEST_RST;
          best_n_nxt = '0;
        end else begin
          np_nxt = np_r + NW'(1);
        end
      end
    end
  end

  // state and output valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r        <= '0;
      match_r     <= '0;
      np_r        <= '0;
      packed_r    <= '0;
      best_s_r    <= BEST_RST;
      best_n_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      wp_r     <= wp_nxt;
      match_r  <= match_nxt;
      np_r     <= np_nxt;
      packed_r <= packed_nxt;
      best_s_r <= best_s_nxt;
      best_n_r <= best_n_nxt;
      if (step_en) begin
        out_valid_r <= has_res;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    if (step_en && has_res) begin
      result_r <= res;
      last_r   <= res_last;
    end
  end

  assign stall      = out_valid_r && !out_ready;
  assign out_valid  = out_valid_r;
  assign out_result = result_r;
  assign out_last   = last_r;

endmodule

`default_nettype wire

/* verif/testbench.sv */
`default_nettype none

module testbench;

  localparam int MAX_BITS      = 1024;
  localparam int MAX_NEURON_CT = 1024;
  localparam int SETTLE_CYCLES = 8;
  localparam int LONG_HOLD     = 400;
  localparam int RANDOM_ITEMS  = 200;
  localparam int CYCLE_LIMIT   = 200000;

  // index with no register behind it, writes to it must be ignored
  localparam logic [bxn_pkg::CFG_IDX_W-1:0] CFG_SPARE = 2'd3;

  // one expected result transfer
  typedef struct {
    bxn_pkg::result_t res;
    logic             done;
  } neuron_result_t;

  // mirror of the layer engine plus the list of results still due
  class neuron_scoreboard;
    logic [bxn_pkg::CFG_W-1:0] len_reg;
    logic [bxn_pkg::CFG_W-1:0] count_reg;
    logic                      mode_reg;
    int               word_pos;
    int               agree_count;
    int               neuron_pos;
    logic [31:0]      packed_acc;
    int               best_score;
    int               best_neuron;
    neuron_result_t   results_due[$];
    int               errors;
    int               results_seen;

    function new();
      len_reg      = bxn_pkg::RST_INPUT_BITS;
      count_reg    = bxn_pkg::RST_NEURON_COUNT;
      mode_reg     = bxn_pkg::MODE_THRESHOLD;
      errors       = 0;
      results_seen = 0;
      clear_layer();
    endfunction

    static function int saturate(int v, int hi);
      if (v < 1) return 1;
      if (v > hi) return hi;
      return v;
    endfunction

    function void clear_layer();
      word_pos    = 0;
      agree_count = 0;
      neuron_pos  = 0;
      packed_acc  = '0;
      best_score  = -2147483647 - 1;
      best_neuron = 0;
    endfunction

    function void write_reg(logic [bxn_pkg::CFG_IDX_W-1:0] idx,
                            logic [bxn_pkg::CFG_W-1:0] val);
      case (idx)
        bxn_pkg::CFG_INPUT_BITS:   len_reg = val;
        bxn_pkg::CFG_NEURON_COUNT: count_reg = val;
        bxn_pkg::CFG_LAYER_MODE:   mode_reg = val[0];
        default: ;
      endcase
    endfunction

    function int pending();
      return results_due.size();
    endfunction

    // xnor-popcount one word, and close the neuron / layer when due
    function void accumulate_word(bxn_pkg::item_t it);
      int             len_eff;
      int             count_eff;
      int             words;
      int             tail;
      int             n;
      int             s;
      logic [31:0]    mask;
      logic [31:0]    agree;
      logic           last_word;
      logic           last_neuron;
      logic           ge;
      neuron_result_t r;
      len_eff   = saturate(int'(len_reg), MAX_BITS);
      count_eff = saturate(int'(count_reg), MAX_NEURON_CT);
      words     = (len_eff + 31) >> 5;
      tail      = len_eff & 31;
      mask      = (tail != 0) ? ((32'h1 << tail) - 32'h1) : 32'hffff_ffff;
      agree     = ~(it.activation_word ^ it.weight_word);
      last_word = (word_pos + 1 >= words);
      if (last_word) agree = agree & mask;
      agree_count = agree_count + $countones(agree);
      if (!last_word) begin
        word_pos++;
        return;
      end
      n           = neuron_pos;
      last_neuron = (n + 1 >= count_eff);
      r.res       = '0;
      r.done      = 1'b0;
      if (mode_reg == bxn_pkg::MODE_THRESHOLD) begin
        ge = (agree_count >= int'(it.threshold));
        if (ge == it.polarity) packed_acc = packed_acc | (32'h1 << (n & 31));
        word_pos    = 0;
        agree_count = 0;
        if (!(((n & 31) == 31) || last_neuron)) begin
          neuron_pos++;
          return;
        end
        r.res.packed_word = packed_acc;
        r.res.word_index  = bxn_pkg::WIDX_W'(n >> 5);
        packed_acc        = '0;
      end else begin
        s = 2 * agree_count - len_eff;
        if (s > best_score) begin
          best_score  = s;
          best_neuron = n;
        end
        r.res.score        = bxn_pkg::SCORE_W'(s);
        r.res.neuron_index = bxn_pkg::NIDX_W'(n);
        if (last_neuron) r.res.prediction = bxn_pkg::NIDX_W'(best_neuron);
        word_pos    = 0;
        agree_count = 0;
      end
      if (last_neuron) begin
        r.done = 1'b1;
        clear_layer();
      end else begin
        neuron_pos++;
      end
      results_due.push_back(r);
    endfunction

    function void compare_field(string field, logic [31:0] want, logic [31:0] got);
      if (want !== got) begin
        errors++;
        $display("%0t: %s mismatch, expected %0h actual %0h", $time, field, want, got);
      end
    endfunction

    // compare one output transfer against the oldest due result
    function void check_neuron_result(bxn_pkg::result_t got, logic got_last);
      neuron_result_t want;
      results_seen++;
      if (results_due.size() == 0) begin
        errors++;
        $display("%0t: unexpected result, expected none actual %0h last %0b",
                 $time, got, got_last);
        return;
      end
      want = results_due.pop_front();
      compare_field("packed_word", 32'(want.res.packed_word), 32'(got.packed_word));
      compare_field("word_index", 32'(want.res.word_index), 32'(got.word_index));
      compare_field("score", 32'(want.res.score), 32'(got.score));
      compare_field("neuron_index", 32'(want.res.neuron_index), 32'(got.neuron_index));
      compare_field("prediction", 32'(want.res.prediction), 32'(got.prediction));
      compare_field("layer_done", 32'(want.done), 32'(got_last));
    endfunction
  endclass

  logic                                clk = 1'b0;
  logic                                rst_n = 1'b0;
  logic [bxn_pkg::IN_TDATA_W-1:0]      in_tdata = '0;
  logic                                in_tvalid = 1'b0;
  wire logic                           in_tready;
  wire logic [bxn_pkg::OUT_TDATA_W-1:0] out_tdata;
  wire logic                           out_tlast;
  wire logic                           out_tvalid;
  logic                                out_tready = 1'b0;
  logic                                cfg_we = 1'b0;
  logic [bxn_pkg::CFG_IDX_W-1:0]       cfg_index = '0;
  logic [bxn_pkg::CFG_W-1:0]           cfg_wdata = '0;

  neuron_scoreboard board;
  int items_sent = 0;
  int layers_set = 0;
  int burst_left = 0;
  int hold_requests = 0;
  int holds_served = 0;
  int hold_left = 0;
  int rx_mode = 0;
  int rx_left = 0;
  int cycles = 0;

  bnn_xnor_popcount_neuron_engine_core DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tdata   (in_tdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata)
  );

  always #10 clk = ~clk;

  // run limit
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results still due", cycles, board.pending());
      $display("DONE: errors detected");
      $finish;
    end
  end

  // result side: check each transfer, stall on a changing pattern or a long hold
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready)
      board.check_neuron_result(
        bxn_pkg::result_t'(out_tdata[$bits(bxn_pkg::result_t)-1:0]), out_tlast);
    if (hold_left > 0) begin
      hold_left--;
      out_tready <= 1'b0;
    end else if (holds_served != hold_requests) begin
      holds_served++;
      hold_left = LONG_HOLD;
      out_tready <= 1'b0;
    end else begin
      if (rx_left == 0) begin
        rx_mode = $urandom_range(0, 3);
        rx_left = $urandom_range(8, 80);
      end
      rx_left--;
      case (rx_mode)
        0:       out_tready <= 1'b1;
        1:       out_tready <= 1'($urandom_range(0, 1));
        2:       out_tready <= ($urandom_range(0, 3) == 0);
        default: out_tready <= ((rx_left % 4) != 0);
      endcase
    end
  end

  function automatic bxn_pkg::item_t mk(logic [31:0] act, logic [31:0] wgt,
                                        logic [15:0] thr, logic pol);
    bxn_pkg::item_t it;
    it.activation_word = act;
    it.weight_word     = wgt;
    it.threshold       = thr;
    it.polarity        = pol;
    return it;
  endfunction

  // random word pair biased toward full, zero and near-full agreement
  function automatic bxn_pkg::item_t random_item(int len_eff);
    bxn_pkg::item_t it;
    it.activation_word = $urandom;
    case ($urandom_range(0, 5))
      0:       it.weight_word = it.activation_word;
      1:       it.weight_word = ~it.activation_word;
      2:       it.weight_word = it.activation_word ^ (32'h1 << $urandom_range(0, 31));
      default: it.weight_word = $urandom;
    endcase
    if ($urandom_range(0, 7) == 0) it.threshold = 16'($urandom);
    else it.threshold = 16'($urandom_range(0, len_eff + 1));
    it.polarity = 1'($urandom_range(0, 1));
    return it;
  endfunction

  // offer one item, in bursts with random gaps, and wait for its transfer
  task automatic send_item(input bxn_pkg::item_t it);
    int gap;
    gap = 0;
    if (burst_left == 0) begin
      burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(60, 150)
                                                : $urandom_range(1, 20);
      gap = $urandom_range(1, 8);
    end
    burst_left--;
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tdata  <= {{(bxn_pkg::IN_TDATA_W-$bits(bxn_pkg::item_t)){1'b0}}, it};
    in_tvalid <= 1'b1;
    do @(posedge clk); while (!in_tready);
    board.accumulate_word(it);
    items_sent++;
  endtask

  // stop offering and wait until every due result has been taken
  task automatic settle();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (board.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [bxn_pkg::CFG_IDX_W-1:0] idx,
                           input logic [bxn_pkg::CFG_W-1:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    board.write_reg(idx, val);
  endtask

  task automatic end_writes();
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_layer(input logic [bxn_pkg::CFG_W-1:0] len,
                           input logic [bxn_pkg::CFG_W-1:0] cnt, input logic mode);
    write_reg(bxn_pkg::CFG_INPUT_BITS, len);
    write_reg(bxn_pkg::CFG_NEURON_COUNT, cnt);
    write_reg(bxn_pkg::CFG_LAYER_MODE, {{(bxn_pkg::CFG_W-1){1'b0}}, mode});
    end_writes();
    layers_set++;
  endtask

  initial begin
    int                        random_items;
    int                        words;
    int                        layer_items;
    logic [bxn_pkg::CFG_W-1:0] len_bits;
    logic [bxn_pkg::CFG_W-1:0] n_neurons;
    logic                      mode_sel;
    board = new();
    random_items = 0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // threshold mode, two words per neuron with an 8-bit tail
    set_layer(11'd40, 11'd3, bxn_pkg::MODE_THRESHOLD);
    send_item(mk(32'hffff_ffff, 32'hffff_ffff, 16'd0, 1'b0));
    send_item(mk(32'h0000_0000, 32'h0000_0000, 16'd40, 1'b1));
    send_item(mk(32'hffff_ffff, 32'h0000_0000, 16'd0, 1'b0));
    send_item(mk(32'hffff_ffff, 32'h0000_0000, 16'd0, 1'b0));
    send_item(mk(32'h0000_0000, 32'hffff_ffff, 16'hffff, 1'b0));
    send_item(mk(32'hffff_ffff, 32'hffff_ffff, 16'hffff, 1'b0));
    settle();

    // score mode, one valid bit, ties keep the earlier neuron
    set_layer(11'd1, 11'd2, bxn_pkg::MODE_SCORE);
    send_item(mk(32'h0000_0001, 32'h0000_0001, 16'd0, 1'b0));
    send_item(mk(32'hffff_ffff, 32'h0000_0001, 16'd0, 1'b1));
    settle();
    set_layer(11'd32, 11'd3, bxn_pkg::MODE_SCORE);
    send_item(mk(32'ha5a5_a5a5, 32'ha5a5_a5a5, 16'd0, 1'b0));
    send_item(mk(32'h0000_0000, 32'hffff_ffff, 16'd0, 1'b0));
    send_item(mk(32'h1234_5678, 32'h1234_5678, 16'd0, 1'b0));
    settle();

    // lengths shortened in the middle of a neuron and of a layer
    set_layer(11'd96, 11'd4, bxn_pkg::MODE_THRESHOLD);
    send_item(random_item(96));
    send_item(random_item(96));
    settle();
    write_reg(bxn_pkg::CFG_INPUT_BITS, 11'd32);
    end_writes();
    send_item(random_item(32));
    settle();
    write_reg(bxn_pkg::CFG_NEURON_COUNT, 11'd1);
    end_writes();
    send_item(random_item(32));
    settle();

    // mode switched mid-layer, packed bits carry over
    set_layer(11'd32, 11'd3, bxn_pkg::MODE_THRESHOLD);
    send_item(mk(32'hffff_ffff, 32'hffff_ffff, 16'd32, 1'b1));
    settle();
    write_reg(bxn_pkg::CFG_LAYER_MODE, {{(bxn_pkg::CFG_W-1){1'b0}}, bxn_pkg::MODE_SCORE});
    end_writes();
    send_item(mk(32'h0f0f_0f0f, 32'h00ff_00ff, 16'd0, 1'b0));
    settle();
    write_reg(bxn_pkg::CFG_LAYER_MODE,
              {{(bxn_pkg::CFG_W-1){1'b0}}, bxn_pkg::MODE_THRESHOLD});
    end_writes();
    send_item(mk(32'h0000_0000, 32'h0000_0000, 16'd0, 1'b1));
    settle();

    // zero registers saturate to one, unused index is ignored
    write_reg(CFG_SPARE, 11'h7ff);
    set_layer(11'd0, 11'd0, bxn_pkg::MODE_SCORE);
    send_item(mk(32'h0000_0001, 32'h0000_0001, 16'd0, 1'b0));
    send_item(mk(32'h0000_0000, 32'h0000_0001, 16'd0, 1'b0));
    settle();

    // full length: oversized register saturates, scores reach both ends
    set_layer(11'd2047, 11'd2, bxn_pkg::MODE_SCORE);
    repeat (32) send_item(mk(32'h5a5a_c3c3, 32'h5a5a_c3c3, 16'd0, 1'b0));
    repeat (32) send_item(mk(32'h5a5a_c3c3, 32'ha5a5_3c3c, 16'd0, 1'b1));
    settle();
    set_layer(11'd1024, 11'd1, bxn_pkg::MODE_THRESHOLD);
    repeat (32) send_item(random_item(MAX_BITS));
    settle();

    // one 300-neuron layer of one-word neurons: packed words first, then scores
    len_bits = 11'($urandom_range(1, 32));
    set_layer(len_bits, 11'd300, bxn_pkg::MODE_THRESHOLD);
    repeat (200) send_item(random_item(int'(len_bits)));
    settle();
    write_reg(bxn_pkg::CFG_LAYER_MODE, {{(bxn_pkg::CFG_W-1){1'b0}}, bxn_pkg::MODE_SCORE});
    end_writes();
    hold_requests++;
    repeat (100) send_item(random_item(int'(len_bits)));
    settle();

    // random small layers, some cut short and resumed under new settings
    while (random_items < RANDOM_ITEMS) begin
      case ($urandom_range(0, 9))
        0:       len_bits = 11'd0;
        1:       len_bits = 11'd32;
        2:       len_bits = 11'd33;
        3:       len_bits = 11'($urandom_range(1025, 2047));
        default: len_bits = 11'($urandom_range(1, 128));
      endcase
      n_neurons = 11'($urandom_range(0, 40));
      mode_sel  = 1'($urandom_range(0, 1));
      words = (neuron_scoreboard::saturate(int'(len_bits), MAX_BITS) + 31) / 32;
      if (words > 8) n_neurons = 11'($urandom_range(0, 2));
      layer_items = words * neuron_scoreboard::saturate(int'(n_neurons), MAX_NEURON_CT);
      if ($urandom_range(0, 4) == 0) layer_items = $urandom_range(1, layer_items);
      if (layer_items > RANDOM_ITEMS - random_items)
        layer_items = RANDOM_ITEMS - random_items;
      set_layer(len_bits, n_neurons, mode_sel);
      repeat (layer_items) begin
        send_item(random_item(neuron_scoreboard::saturate(int'(len_bits), MAX_BITS)));
        random_items++;
      end
      settle();
    end

    $display("run covered %0d input transfers and %0d result transfers over %0d layer setups",
             items_sent, board.results_seen, layers_set);
    $display("both modes, saturated lengths, mid-layer length and mode changes, long stall");
    if (board.errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("%0d mismatches", board.errors);
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

`default_nettype wire

/* bnn_xnor_popcount_neuron_engine_core.f */
hdl/bxn_pkg.sv
hdl/bxn_popcount.sv
hdl/bxn_layer.sv
hdl/bnn_xnor_popcount_neuron_engine_core.sv
verif/testbench.sv
